>>> sv/psg_pkg.sv
// Package for the pulse/saw sound generator: channel count, command and register codes.
package psg_pkg;

  localparam int PULSE_CHANNELS = 2;

  localparam int PERIOD_W = 12;
  localparam int POS_W    = 4;
  localparam int VOL_W    = 4;
  localparam int THR_W    = 3;
  localparam int ACC_W    = 8;
  localparam int RATE_W   = 6;
  localparam int MIX_W    = 6;

  // item command
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // address bits 15:12 after the 0xF003 mask
  localparam logic [3:0] PAGE_PULSE0 = 4'h9;
  localparam logic [3:0] PAGE_SAW    = 4'hB;

  // address bits 1:0 after the 0xF003 mask
  localparam logic [1:0] REG_VOL    = 2'd0;
  localparam logic [1:0] REG_LOW    = 2'd1;
  localparam logic [1:0] REG_HIGH   = 2'd2;
  localparam logic [1:0] REG_GLOBAL = 2'd3;

  localparam logic [POS_W-1:0] POS_DISABLED = 4'd15;
  localparam logic [3:0]       SAW_STEPS    = 4'd14;

endpackage

>>> sv/pulse_saw_sound_generator_core.sv
// Two-pulse, one-sawtooth sound generator core with registered mixed-level output.
//
//   channel  | signals                             | role
//   ---------+-------------------------------------+---------------------------------
//   in       | in_valid, in_ready, cmd, address,   | register write or one clock tick
//            | value                               |
//   out      | out_valid, out_ready, mix_level     | mixed level after each item
//
// One item per cycle while in_ready is high: an accepted item updates the channel
// state and the mixed level of the new state is registered into the output stage in
// the same edge. out_valid rises in the cycle after an item is accepted.
// in_ready is low only while a result sits in the output register and out_ready is low.
// rst (synchronous) clears all channel state and out_valid; mix_level is not reset.
module pulse_saw_sound_generator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [15:0] address,
  input  logic [7:0]  value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  mix_level
);

  localparam int NCH = psg_pkg::PULSE_CHANNELS;

  logic [psg_pkg::PERIOD_W-1:0] pulse_counter   [NCH];
  logic [psg_pkg::PERIOD_W-1:0] pulse_period    [NCH];
  logic [psg_pkg::POS_W-1:0]    pulse_position  [NCH];
  logic [psg_pkg::VOL_W-1:0]    pulse_volume    [NCH];
  logic [psg_pkg::THR_W-1:0]    pulse_threshold [NCH];
  logic                         pulse_constant  [NCH];
  logic                         pulse_on        [NCH];

  logic [psg_pkg::PERIOD_W-1:0] pulse_counter_next   [NCH];
  logic [psg_pkg::PERIOD_W-1:0] pulse_period_next    [NCH];
  logic [psg_pkg::POS_W-1:0]    pulse_position_next  [NCH];
  logic [psg_pkg::VOL_W-1:0]    pulse_volume_next    [NCH];
  logic [psg_pkg::THR_W-1:0]    pulse_threshold_next [NCH];
  logic                         pulse_constant_next  [NCH];
  logic                         pulse_on_next        [NCH];

  logic                         halt_flag, halt_flag_next;
  logic [3:0]                   period_shift, period_shift_next;
  logic [psg_pkg::PERIOD_W-1:0] saw_counter, saw_counter_next;
  logic [psg_pkg::PERIOD_W-1:0] saw_period, saw_period_next;
  logic [3:0]                   saw_phase, saw_phase_next;
  logic [psg_pkg::ACC_W-1:0]    saw_accumulator, saw_accumulator_next;
  logic [psg_pkg::RATE_W-1:0]   saw_rate, saw_rate_next;
  logic                         saw_on, saw_on_next;

  logic                         accept;
  logic [3:0]                   page;
  logic [1:0]                   reg_sel;
  logic                         is_write;
  logic                         is_tick;
  logic [psg_pkg::PERIOD_W-1:0] pulse_reload [NCH];
  logic [3:0]                   saw_phase_inc;
  logic [psg_pkg::MIX_W-1:0]    mix_next;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign page     = address[15:12];
  assign reg_sel  = address[1:0];
  assign is_write = accept && (cmd == psg_pkg::CMD_WRITE);
  assign is_tick  = accept && (cmd == psg_pkg::CMD_TICK);

  always_comb begin
    halt_flag_next       = halt_flag;
    period_shift_next    = period_shift;
    saw_counter_next     = saw_counter;
    saw_period_next      = saw_period;
    saw_phase_next       = saw_phase;
    saw_accumulator_next = saw_accumulator;
    saw_rate_next        = saw_rate;
    saw_on_next          = saw_on;
    saw_phase_inc        = saw_phase + 4'd1;

    for (int ch = 0; ch < NCH; ch++) begin
      pulse_counter_next[ch]   = pulse_counter[ch];
      pulse_period_next[ch]    = pulse_period[ch];
      pulse_position_next[ch]  = pulse_position[ch];
      pulse_volume_next[ch]    = pulse_volume[ch];
      pulse_threshold_next[ch] = pulse_threshold[ch];
      pulse_constant_next[ch]  = pulse_constant[ch];
      pulse_on_next[ch]        = pulse_on[ch];
      pulse_reload[ch]         = pulse_period[ch] >> period_shift;

      if (is_write && page == 4'(psg_pkg::PAGE_PULSE0 + 4'(ch))) begin
        unique case (reg_sel)
          psg_pkg::REG_VOL: begin
            pulse_volume_next[ch]    = value[3:0];
            pulse_threshold_next[ch] = value[6:4];
            pulse_constant_next[ch]  = value[7];
          end
          psg_pkg::REG_LOW: begin
            pulse_period_next[ch][7:0] = value;
          end
          psg_pkg::REG_HIGH: begin
            pulse_period_next[ch][11:8] = value[3:0];
            pulse_on_next[ch]           = value[7];
            if (!value[7]) begin
              pulse_position_next[ch] = psg_pkg::POS_DISABLED;
            end
          end
          default: begin
            // global control on the first page is handled below
          end
        endcase
      end

      if (is_tick && !halt_flag) begin
        if (pulse_counter[ch] == '0) begin
          pulse_counter_next[ch] = pulse_reload[ch];
          if (pulse_on[ch]) begin
            pulse_position_next[ch] = pulse_position[ch] - 4'd1;
          end
        end else begin
          pulse_counter_next[ch] = pulse_counter[ch] - 12'd1;
        end
      end
    end

    if (is_write && page == psg_pkg::PAGE_PULSE0 && reg_sel == psg_pkg::REG_GLOBAL) begin
      halt_flag_next = value[0];
      priority if (value[2]) begin
        period_shift_next = 4'd8;
      end else if (value[1]) begin
        period_shift_next = 4'd4;
      end else begin
        period_shift_next = 4'd0;
      end
    end

    if (is_write && page == psg_pkg::PAGE_SAW) begin
      unique case (reg_sel)
        psg_pkg::REG_VOL: begin
          saw_rate_next = value[5:0];
        end
        psg_pkg::REG_LOW: begin
          saw_period_next[7:0] = value;
        end
        psg_pkg::REG_HIGH: begin
          saw_period_next[11:8] = value[3:0];
          saw_on_next           = value[7];
          if (!value[7]) begin
            saw_accumulator_next = '0;
          end
        end
        default: begin
          // no saw register at this slot
        end
      endcase
    end

    if (is_tick) begin
      if (saw_counter == '0) begin
        saw_counter_next = saw_period;
        saw_phase_next   = saw_phase_inc;
        if (saw_phase[0]) begin
          saw_accumulator_next = saw_accumulator + 8'(saw_rate);
        end
        // end of the sawtooth cycle: restart the ramp
        if (saw_phase_inc >= psg_pkg::SAW_STEPS) begin
          saw_phase_next       = '0;
          saw_accumulator_next = '0;
        end
      end else begin
        saw_counter_next = saw_counter - 12'd1;
      end
    end

    mix_next = '0;
    for (int ch = 0; ch < NCH; ch++) begin
      if (pulse_on_next[ch] && (pulse_constant_next[ch] ||
          pulse_position_next[ch] <= 4'(pulse_threshold_next[ch]))) begin
        mix_next = mix_next + 6'(pulse_volume_next[ch]);
      end
    end
    if (saw_on_next) begin
      mix_next = mix_next + 6'(saw_accumulator_next[7:3]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int ch = 0; ch < NCH; ch++) begin
        pulse_counter[ch]   <= '0;
        pulse_period[ch]    <= '0;
        pulse_position[ch]  <= '0;
        pulse_volume[ch]    <= '0;
        pulse_threshold[ch] <= '0;
        pulse_constant[ch]  <= 1'b0;
        pulse_on[ch]        <= 1'b0;
      end
      halt_flag       <= 1'b0;
      period_shift    <= '0;
      saw_counter     <= '0;
      saw_period      <= '0;
      saw_phase       <= '0;
      saw_accumulator <= '0;
      saw_rate        <= '0;
      saw_on          <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      for (int ch = 0; ch < NCH; ch++) begin
        pulse_counter[ch]   <= pulse_counter_next[ch];
        pulse_period[ch]    <= pulse_period_next[ch];
        pulse_position[ch]  <= pulse_position_next[ch];
        pulse_volume[ch]    <= pulse_volume_next[ch];
        pulse_threshold[ch] <= pulse_threshold_next[ch];
        pulse_constant[ch]  <= pulse_constant_next[ch];
        pulse_on[ch]        <= pulse_on_next[ch];
      end
      halt_flag       <= halt_flag_next;
      period_shift    <= period_shift_next;
      saw_counter     <= saw_counter_next;
      saw_period      <= saw_period_next;
      saw_phase       <= saw_phase_next;
      saw_accumulator <= saw_accumulator_next;
      saw_rate        <= saw_rate_next;
      saw_on          <= saw_on_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload: load on every accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      mix_level <= mix_next;
    end
  end

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    saw_phase < psg_pkg::SAW_STEPS)
    else $error("saw phase left its 14-step range");

  a_saw_off_clears: assert property (@(posedge clk) disable iff (rst)
    (is_write && page == psg_pkg::PAGE_SAW && reg_sel == psg_pkg::REG_HIGH && !value[7])
    |=> (saw_accumulator == '0 && !saw_on))
    else $error("saw disable did not clear the accumulator");

  a_halt_freezes: assert property (@(posedge clk) disable iff (rst)
    (is_tick && halt_flag) |=> (pulse_counter[0] == $past(pulse_counter[0])))
    else $error("pulse divider moved while halted");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a pending result");

  a_mix_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (mix_level <= 6'd61))
    else $error("mixed level out of range");

endmodule
